>>> rtl/core/q16alu_pkg.sv
// Shared types and operation codes for the Q16.16 fixed-point unit.
// Used by q16alu_div and q16_16_fixed_point_alu; depends on nothing.
`timescale 1ns / 1ps

package q16alu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_NEG     = 4'd4;
    localparam logic [3:0] OP_ADD_INT = 4'd5;
    localparam logic [3:0] OP_SUB_INT = 4'd6;
    localparam logic [3:0] OP_MUL_INT = 4'd7;
    localparam logic [3:0] OP_DIV_INT = 4'd8;
    localparam logic [3:0] OP_TO_INT  = 4'd9;
    localparam logic [3:0] OP_COMPARE = 4'd10;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result;
        logic               less;
        logic               equal;
        logic               div_zero;
        logic               overflow;
    } t_rsp;

    typedef struct packed {
        logic [3:0] op;
        t_rsp       rsp;
    } t_side;

endpackage

>>> rtl/core/q16alu_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Carries a t_side word alongside each quotient; uses q16alu_pkg.
`timescale 1ns / 1ps

module q16alu_div
    import q16alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QW = 32 + FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [QW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    input  logic          i_neg,
    output logic          o_valid,
    output t_side         o_side,
    output logic [QW-1:0] o_quo,
    output logic          o_neg
);

    logic          r_v    [QW];
    t_side         r_side [QW];
    logic [31:0]   r_rem  [QW];
    logic [QW-1:0] r_d    [QW];
    logic [31:0]   r_dvs  [QW];
    logic          r_neg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic          v_in;
        t_side         side_in;
        logic [31:0]   rem_in;
        logic [QW-1:0] d_in;
        logic [31:0]   dvs_in;
        logic          neg_in;
        logic [32:0]   trial;
        logic          ge;
        logic [31:0]   n_rem;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign rem_in  = 32'd0;
            assign d_in    = i_dividend;
            assign dvs_in  = i_divisor;
            assign neg_in  = i_neg;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
            assign rem_in  = r_rem[k-1];
            assign d_in    = r_d[k-1];
            assign dvs_in  = r_dvs[k-1];
            assign neg_in  = r_neg[k-1];
        end

        assign trial = {rem_in, d_in[QW-1]};
        assign ge    = trial >= {1'b0, dvs_in};
        assign n_rem = ge ? 32'(trial - {1'b0, dvs_in}) : trial[31:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_side[k] <= side_in;
                r_rem[k]  <= n_rem;
                r_d[k]    <= {d_in[QW-2:0], ge};
                r_dvs[k]  <= dvs_in;
                r_neg[k]  <= neg_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quo   = r_d[QW-1];
    assign o_neg   = r_neg[QW-1];

endmodule

>>> rtl/core/q16_16_fixed_point_alu.sv
// Top level of the signed Q16.16 fixed-point unit.
// Instantiates q16alu_div; uses q16alu_pkg.
//
// Requests arrive on i_valid/o_stall with an i_req word (operation code and
// two signed operands). Each request yields exactly one o_rsp word on
// o_valid/i_stall, in request order.
// The unit accepts one word per cycle unless o_stall is high. Every operation
// passes the same registers in order: the first register, which takes the
// multiplier and the simple operations, the divider pipeline, which retires
// one quotient bit per stage, and the output register after the sign fix.
// All operations travel through the same pipeline so results stay ordered.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits, so the pipeline comes up empty.
`timescale 1ns / 1ps

module q16_16_fixed_point_alu
    import q16alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int QW = 32 + FRAC_BITS;
    localparam int AW = 34 + FRAC_BITS;

    logic en;

    logic               r_s1_v;
    t_side              r_s1_side;
    logic signed [63:0] r_s1_prod;
    logic [QW-1:0]      r_s1_dvd;
    logic [31:0]        r_s1_dvs;
    logic               r_s1_neg;

    logic r_out_v;
    t_rsp r_out;

    t_side              n_side;
    logic signed [32:0] ea, eb, s33;
    logic signed [AW-1:0] wa, wb, sw;
    logic [31:0]        abs_a, abs_b;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;

    assign ea    = {i_req.operand_a[31], i_req.operand_a};
    assign eb    = {i_req.operand_b[31], i_req.operand_b};
    assign wa    = AW'(i_req.operand_a);
    assign wb    = AW'(i_req.operand_b) <<< FRAC_BITS;
    assign abs_a = i_req.operand_a[31] ? 32'(-ea) : i_req.operand_a;
    assign abs_b = i_req.operand_b[31] ? 32'(-eb) : i_req.operand_b;

    always_comb begin
        n_side     = '0;
        n_side.op  = i_req.req_type;
        s33        = '0;
        sw         = '0;
        case (i_req.req_type)
            OP_ADD, OP_SUB, OP_NEG: begin
                if (i_req.req_type == OP_ADD) begin
                    s33 = ea + eb;
                end else if (i_req.req_type == OP_SUB) begin
                    s33 = ea - eb;
                end else begin
                    s33 = -ea;
                end
                n_side.rsp.result   = s33[31:0];
                n_side.rsp.overflow = s33[32] != s33[31];
            end
            OP_ADD_INT, OP_SUB_INT: begin
                sw = (i_req.req_type == OP_ADD_INT) ? wa + wb : wa - wb;
                n_side.rsp.result   = sw[31:0];
                n_side.rsp.overflow = sw[AW-1:31] != {(AW-31){sw[31]}};
            end
            OP_TO_INT: begin
                s33 = (ea + (i_req.operand_a[31] ? 33'((64'sd1 <<< FRAC_BITS) - 64'sd1)
                                                 : 33'sd0)) >>> FRAC_BITS;
                n_side.rsp.result = s33[31:0];
            end
            OP_DIV, OP_DIV_INT: begin
                n_side.rsp.div_zero = i_req.operand_b == 32'sd0;
            end
            OP_COMPARE: begin
                n_side.rsp.less  = i_req.operand_a < i_req.operand_b;
                n_side.rsp.equal = i_req.operand_a == i_req.operand_b;
            end
            default: begin
                n_side.rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
        end
        if (en) begin
            r_s1_side <= n_side;
            r_s1_prod <= i_req.operand_a * i_req.operand_b;
            r_s1_dvd  <= (i_req.req_type == OP_DIV) ? (QW'(abs_a) << FRAC_BITS)
                                                     : QW'(abs_a);
            r_s1_dvs  <= abs_b;
            r_s1_neg  <= i_req.operand_a[31] ^ i_req.operand_b[31];
        end
    end

    // Multiply results are finished here, before entering the divider line.
    t_side              div_side;
    logic signed [63:0] pq;

    always_comb begin
        div_side = r_s1_side;
        pq       = '0;
        case (r_s1_side.op)
            OP_MUL: begin
                pq = (r_s1_prod + (r_s1_prod[63] ? (64'sd1 <<< FRAC_BITS) - 64'sd1
                                                 : 64'sd0)) >>> FRAC_BITS;
                div_side.rsp.result   = pq[31:0];
                div_side.rsp.overflow = pq[63:31] != {33{pq[31]}};
            end
            OP_MUL_INT: begin
                div_side.rsp.result   = r_s1_prod[31:0];
                div_side.rsp.overflow = r_s1_prod[63:31] != {33{r_s1_prod[31]}};
            end
            default: begin
                div_side = r_s1_side;
            end
        endcase
    end

    logic          d_v;
    t_side         d_side;
    logic [QW-1:0] d_quo;
    logic          d_neg;

    q16alu_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_s1_v),
        .i_side    (div_side),
        .i_dividend(r_s1_dvd),
        .i_divisor (r_s1_dvs),
        .i_neg     (r_s1_neg),
        .o_valid   (d_v),
        .o_side    (d_side),
        .o_quo     (d_quo),
        .o_neg     (d_neg)
    );

    t_rsp            n_out;
    logic [QW:0]     qs;

    always_comb begin
        n_out = d_side.rsp;
        qs    = d_neg ? (QW+1)'(-{1'b0, d_quo}) : {1'b0, d_quo};
        case (d_side.op)
            OP_DIV, OP_DIV_INT: begin
                if (!d_side.rsp.div_zero) begin
                    n_out.result   = qs[31:0];
                    n_out.overflow = qs[QW:31] != {(QW-30){qs[31]}};
                end
            end
            default: begin
                n_out = d_side.rsp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_v;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.div_zero |-> r_out.result == 32'sd0 && !r_out.overflow)
        else $error("division by zero result not cleared");

    a_cmp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.less && r_out.equal))
        else $error("less and equal both set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && i_stall |=> r_out_v && $stable(r_out))
        else $error("stalled result changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_v && i_stall)
        else $error("input stalled without a blocked result");

endmodule

>>> dv/q16alu_checker.sv
// Checker for the Q16.16 fixed-point unit: watches both channels, predicts each response word
// from the request word, and compares them in order. Depends on q16alu_pkg.
`timescale 1ns / 1ps

module q16alu_checker
    import q16alu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall_req,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_stall_rsp,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending
);

    localparam int FB = FRAC_BITS_DEF;

    t_rsp expected_q[$];
    int   err_cnt = 0;

    function automatic logic [31:0] fit(input logic signed [95:0] v, inout logic ov);
        if (v < -96'sd2147483648 || v > 96'sd2147483647) ov = 1'b1;
        return v[31:0];
    endfunction

    function automatic t_rsp fixed_point_result(input t_req rq);
        logic signed [95:0] a;
        logic signed [95:0] b;
        logic signed [95:0] sc;
        t_rsp r;
        logic ov;
        a = rq.operand_a;
        b = rq.operand_b;
        sc = 96'sd1 <<< FB;
        r = '0;
        ov = 1'b0;
        case (rq.req_type)
            OP_ADD:     r.result = fit(a + b, ov);
            OP_SUB:     r.result = fit(a - b, ov);
            OP_MUL:     r.result = fit((a * b) / sc, ov);
            OP_DIV: begin
                if (b == 0) r.div_zero = 1'b1;
                else r.result = fit((a * sc) / b, ov);
            end
            OP_NEG:     r.result = fit(-a, ov);
            OP_ADD_INT: r.result = fit(a + b * sc, ov);
            OP_SUB_INT: r.result = fit(a - b * sc, ov);
            OP_MUL_INT: r.result = fit(a * b, ov);
            OP_DIV_INT: begin
                if (b == 0) r.div_zero = 1'b1;
                else r.result = fit(a / b, ov);
            end
            OP_TO_INT:  r.result = fit(a / sc, ov);
            OP_COMPARE: begin
                r.less = a < b;
                r.equal = a == b;
            end
            default: ;
        endcase
        r.overflow = ov;
        return r;
    endfunction

    assign o_pending = expected_q.size();
    assign o_errors  = err_cnt;

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && i_valid && !i_stall_req) expected_q.push_back(fixed_point_result(i_req));
        if (i_rst_n && i_rsp_valid && !i_stall_rsp) begin
            if (expected_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < 10) $display("unexpected word %h", i_rsp);
            end else begin
                want = expected_q.pop_front();
                if (want !== i_rsp) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10)
                        $display({"mismatch: exp res %h lt %b eq %b dz %b ov %b, ",
                                  "got res %h lt %b eq %b dz %b ov %b"},
                                 want.result, want.less, want.equal, want.div_zero,
                                 want.overflow, i_rsp.result, i_rsp.less, i_rsp.equal,
                                 i_rsp.div_zero, i_rsp.overflow);
                end
            end
        end
    end

endmodule

>>> dv/tb.sv
// Testbench top for the Q16.16 fixed-point unit: directed and random request words under
// several idling phases. Depends on q16alu_pkg, q16_16_fixed_point_alu and q16alu_checker.
`timescale 1ns / 1ps

module tb;
    import q16alu_pkg::*;

    localparam int LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;
    int   errors;
    int   pending;
    int   quiet = 0;
    int   send_idle = 0;
    int   recv_stall = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    q16_16_fixed_point_alu u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    q16alu_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_req(o_stall),
        .i_req(i_req), .i_rsp_valid(o_valid), .i_stall_rsp(i_stall), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_stall);
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            5: return 32'hFFFF_0000;
            6: return $urandom_range(65535) - 32768;
            7: return ($urandom_range(255) - 128) << 16 | $urandom_range(65535);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= '{req_type: op, operand_a: a, operand_b: b};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] edges [6];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int op = 0; op < 16; op++) send_word(4'(op), edges[op % 6], edges[(op + 3) % 6]);
        send_word(OP_DIV, 32'h0001_0000, 32'h0);
        send_word(OP_DIV_INT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(OP_NEG, 32'h8000_0000, 32'h0);
        send_word(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(OP_COMPARE, 32'h1234_5678, 32'h1234_5678);
        send_word(OP_TO_INT, 32'hFFFE_8000, 32'h0);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 84; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 84; end
                3: begin send_idle = 6; recv_stall = 6; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            for (int n = 0; n < 310; n++)
                send_word(($urandom_range(99) < 95) ? 4'($urandom_range(10))
                                                    : 4'($urandom_range(15)),
                          pick_operand(), pick_operand());
            drain();
        end
        recv_stall = 0;
        repeat (80) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/q16alu_pkg.sv
rtl/core/q16alu_div.sv
rtl/core/q16_16_fixed_point_alu.sv
dv/q16alu_checker.sv
dv/tb.sv
